// ===== design/triangle_tangent_frame_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the triangle tangent frame checks
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_FRAME_ASSERT_SVH
`define TRIANGLE_TANGENT_FRAME_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ttf_pkg.sv =====
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared types for the triangle tangent frame block.
// ----------------------------------------------------------------------------
package ttf_pkg;

  typedef logic signed [32:0] pos_delta_t;
  typedef logic signed [24:0] uv_delta_t;

  // One triangle handed from the front end to the back end.
  typedef struct packed {
    logic [31:0] idx0;
    logic [31:0] idx1;
    logic [31:0] idx2;
    pos_delta_t  dp1_x;
    pos_delta_t  dp1_y;
    pos_delta_t  dp1_z;
    pos_delta_t  dp2_x;
    pos_delta_t  dp2_y;
    pos_delta_t  dp2_z;
    uv_delta_t   du1;
    uv_delta_t   dv1;
    uv_delta_t   du2;
    uv_delta_t   dv2;
  } job_t;

  localparam logic [15:0] UNIT_MAX = 16'd32767;

endpackage

// ===== design/ttf_channels.sv =====
// ----------------------------------------------------------------------------
// Channel interfaces
// Vertex input channel and tangent frame output channel, valid/ready.
// ----------------------------------------------------------------------------
interface ttf_vertex_if;
  logic               valid;
  logic               ready;
  logic        [31:0] vertex_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [23:0] tex_u;
  logic signed [23:0] tex_v;

  modport source (output valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  input ready);
  modport sink (input valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                output ready);
endinterface

interface ttf_frame_if;
  logic               valid;
  logic               ready;
  logic        [31:0] target_index;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_y;
  logic signed [15:0] tangent_z;
  logic signed [15:0] bitangent_x;
  logic signed [15:0] bitangent_y;
  logic signed [15:0] bitangent_z;
  logic               degenerate;
  logic               last_of_triangle;

  modport source (output valid, target_index, tangent_x, tangent_y, tangent_z,
                  bitangent_x, bitangent_y, bitangent_z, degenerate,
                  last_of_triangle, input ready);
  modport sink (input valid, target_index, tangent_x, tangent_y, tangent_z,
                bitangent_x, bitangent_y, bitangent_z, degenerate,
                last_of_triangle, output ready);
endinterface

// ===== design/ttf_queue.sv =====
// ----------------------------------------------------------------------------
// ttf_queue
// Two-entry triangle queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ttf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ttf_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output ttf_pkg::job_t pop_data
);

  ttf_pkg::job_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/ttf_front.sv =====
// ----------------------------------------------------------------------------
// ttf_front
// Collects the corners of each triangle and forms the edge and UV deltas.
// ----------------------------------------------------------------------------
module ttf_front #(
  parameter int INDEX_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  ttf_vertex_if.sink    vertex_in,
  input  logic          q_full,
  output logic          q_push,
  output ttf_pkg::job_t q_data
);

  logic [1:0]            corner_count;
  logic [INDEX_BITS-1:0] held_index [2];
  logic signed [31:0]    held_pos [6];
  logic signed [23:0]    held_uv [4];
  logic                  accept;

  assign vertex_in.ready = (corner_count != 2'd2) || !q_full;
  assign accept          = vertex_in.valid && vertex_in.ready;
  assign q_push          = accept && (corner_count == 2'd2);

  always_comb begin
    q_data.idx0  = 32'(held_index[0]);
    q_data.idx1  = 32'(held_index[1]);
    q_data.idx2  = 32'(vertex_in.vertex_index[INDEX_BITS-1:0]);
    q_data.dp1_x = 33'(held_pos[3]) - 33'(held_pos[0]);
    q_data.dp1_y = 33'(held_pos[4]) - 33'(held_pos[1]);
    q_data.dp1_z = 33'(held_pos[5]) - 33'(held_pos[2]);
    q_data.dp2_x = 33'(vertex_in.pos_x) - 33'(held_pos[0]);
    q_data.dp2_y = 33'(vertex_in.pos_y) - 33'(held_pos[1]);
    q_data.dp2_z = 33'(vertex_in.pos_z) - 33'(held_pos[2]);
    q_data.du1   = 25'(held_uv[2]) - 25'(held_uv[0]);
    q_data.dv1   = 25'(held_uv[3]) - 25'(held_uv[1]);
    q_data.du2   = 25'(vertex_in.tex_u) - 25'(held_uv[0]);
    q_data.dv2   = 25'(vertex_in.tex_v) - 25'(held_uv[1]);
  end

  always_ff @(posedge clk) begin
    if (accept && (corner_count == 2'd0)) begin
      held_index[0] <= vertex_in.vertex_index[INDEX_BITS-1:0];
      held_pos[0]   <= vertex_in.pos_x;
      held_pos[1]   <= vertex_in.pos_y;
      held_pos[2]   <= vertex_in.pos_z;
      held_uv[0]    <= vertex_in.tex_u;
      held_uv[1]    <= vertex_in.tex_v;
    end
    if (accept && (corner_count == 2'd1)) begin
      held_index[1] <= vertex_in.vertex_index[INDEX_BITS-1:0];
      held_pos[3]   <= vertex_in.pos_x;
      held_pos[4]   <= vertex_in.pos_y;
      held_pos[5]   <= vertex_in.pos_z;
      held_uv[2]    <= vertex_in.tex_u;
      held_uv[3]    <= vertex_in.tex_v;
    end
    if (rst) begin
      corner_count <= 2'd0;
    end else if (accept) begin
      corner_count <= (corner_count == 2'd2) ? 2'd0 : corner_count + 2'd1;
    end
  end

endmodule

// ===== design/ttf_back.sv =====
// ----------------------------------------------------------------------------
// ttf_back
// Tangent and bitangent, normalized unless degenerate; emits three results.
// ----------------------------------------------------------------------------
module ttf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ttf_pkg::job_t q_data,
  output logic          q_pop,
  ttf_frame_if.source   frame_out
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SIGN, S_PREP, S_SHIFT, S_SQ, S_SRINIT, S_SQRT,
    S_DINIT, S_DIV, S_STORE, S_EMIT
  } state_t;

  state_t             state;
  ttf_pkg::job_t      job;
  logic [3:0]         step;
  logic signed [50:0] det;
  logic signed [58:0] vec [6];
  logic               sel;
  logic [58:0]        mag [3];
  logic               neg [3];
  logic [61:0]        len2;
  logic [61:0]        sq_x;
  logic [61:0]        sq_r;
  logic [61:0]        sq_b;
  logic [4:0]         cnt;
  logic [1:0]         comp;
  logic [45:0]        num;
  logic [32:0]        rem;
  logic [16:0]        quo;
  logic signed [15:0] res [6];
  logic               degen;
  logic [1:0]         k;

  logic               out_valid;
  logic [31:0]        out_index;
  logic signed [15:0] out_vec [6];
  logic               out_degen;
  logic               out_last;

  // Product sequencing
  ttf_pkg::pos_delta_t dp1 [3];
  ttf_pkg::pos_delta_t dp2 [3];
  logic signed [24:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [57:0]  prod;
  logic [2:0]          tgt;
  logic                sub;
  logic                is_det;
  logic [3:0]          s2;

  assign dp1[0] = job.dp1_x;
  assign dp1[1] = job.dp1_y;
  assign dp1[2] = job.dp1_z;
  assign dp2[0] = job.dp2_x;
  assign dp2[1] = job.dp2_y;
  assign dp2[2] = job.dp2_z;
  assign s2     = step - 4'd2;
  assign is_det = (step < 4'd2);

  always_comb begin
    mul_a = job.dv2;
    mul_b = dp1[s2[3:2]];
    tgt   = {1'b0, s2[3:2]};
    sub   = 1'b0;
    if (step == 4'd0) begin
      mul_a = job.du1;
      mul_b = 33'(job.dv2);
    end else if (step == 4'd1) begin
      mul_a = job.du2;
      mul_b = 33'(job.dv1);
      sub   = 1'b1;
    end else begin
      case (s2[1:0])
        2'd0: begin
          mul_a = job.dv2;
          mul_b = dp1[s2[3:2]];
        end
        2'd1: begin
          mul_a = job.dv1;
          mul_b = dp2[s2[3:2]];
          sub   = 1'b1;
        end
        2'd2: begin
          mul_a = job.du1;
          mul_b = dp2[s2[3:2]];
          tgt   = 3'd3 + {1'b0, s2[3:2]};
        end
        default: begin
          mul_a = job.du2;
          mul_b = dp1[s2[3:2]];
          tgt   = 3'd3 + {1'b0, s2[3:2]};
          sub   = 1'b1;
        end
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  // Largest magnitude of the vector under normalization
  logic [58:0] m01;
  logic [58:0] mmax;
  assign m01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign mmax = (m01 > mag[2]) ? m01 : mag[2];

  logic [29:0] sq_in;
  logic [59:0] sq_out;
  assign sq_in  = mag[cnt[1:0]][29:0];
  assign sq_out = sq_in * sq_in;

  logic [61:0] sq_t;
  assign sq_t = sq_r + sq_b;

  logic [45:0] num_init;
  assign num_init = {mag[comp][29:0], 15'd0} + 46'(sq_r[31:1]);

  logic [32:0] div_t;
  logic [32:0] div_l;
  assign div_t = {rem[31:0], num[16]};
  assign div_l = {1'b0, sq_r[31:0]};

  logic [15:0] q_sat;
  assign q_sat = (quo > 17'(ttf_pkg::UNIT_MAX)) ? ttf_pkg::UNIT_MAX : quo[15:0];

  logic [2:0] store_idx;
  assign store_idx = (sel ? 3'd3 : 3'd0) + {1'b0, comp};

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The emit state sets valid itself, so the clear applies elsewhere only.
      if (out_valid && frame_out.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job   <= q_data;
            det   <= '0;
            for (int i = 0; i < 6; i++) begin
              vec[i] <= '0;
            end
            degen <= 1'b0;
            step  <= 4'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (is_det) begin
            det <= sub ? det - 51'(prod) : det + 51'(prod);
          end else begin
            vec[tgt] <= sub ? vec[tgt] - 59'(prod) : vec[tgt] + 59'(prod);
          end
          step <= step + 4'd1;
          if (step == 4'd13) begin
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (det == '0) begin
            degen <= 1'b1;
            k     <= 2'd0;
            state <= S_EMIT;
          end else begin
            if (det < 0) begin
              for (int i = 0; i < 6; i++) begin
                vec[i] <= -vec[i];
              end
            end
            sel   <= 1'b0;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec[3'(sel ? 3 + i : i)] < 0;
            mag[i] <= (vec[3'(sel ? 3 + i : i)] < 0) ?
                      59'(-vec[3'(sel ? 3 + i : i)]) : 59'(vec[3'(sel ? 3 + i : i)]);
          end
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          // One bit per cycle until the largest magnitude tops out at bit 29.
          if (mmax == '0) begin
            degen <= 1'b1;
            k     <= 2'd0;
            state <= S_EMIT;
          end else if (mmax[58:30] != '0) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else if (!mmax[29]) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            len2  <= '0;
            cnt   <= 5'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          len2 <= len2 + 62'(sq_out);
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd2) begin
            state <= S_SRINIT;
          end
        end
        S_SRINIT: begin
          sq_x  <= len2;
          sq_r  <= '0;
          sq_b  <= 62'd1 << 60;
          cnt   <= 5'd0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_x >= sq_t) begin
            sq_x <= sq_x - sq_t;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            comp  <= 2'd0;
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          num   <= num_init;
          rem   <= 33'(num_init[45:17]);
          quo   <= '0;
          cnt   <= 5'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_t >= div_l) begin
            rem <= div_t - div_l;
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= div_t;
            quo <= {quo[15:0], 1'b0};
          end
          num <= num << 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          res[store_idx] <= neg[comp] ? -$signed(q_sat) : $signed(q_sat);
          if (comp == 2'd2) begin
            if (!sel) begin
              sel   <= 1'b1;
              state <= S_PREP;
            end else begin
              k     <= 2'd0;
              state <= S_EMIT;
            end
          end else begin
            comp  <= comp + 2'd1;
            state <= S_DINIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || frame_out.ready) begin
            out_valid <= 1'b1;
            case (k)
              2'd0:    out_index <= job.idx0;
              2'd1:    out_index <= job.idx1;
              default: out_index <= job.idx2;
            endcase
            for (int i = 0; i < 6; i++) begin
              out_vec[i] <= degen ? 16'sd0 : res[i];
            end
            out_degen <= degen;
            out_last  <= (k == 2'd2);
            k         <= k + 2'd1;
            if (k == 2'd2) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign frame_out.valid            = out_valid;
  assign frame_out.target_index     = out_index;
  assign frame_out.tangent_x        = out_vec[0];
  assign frame_out.tangent_y        = out_vec[1];
  assign frame_out.tangent_z        = out_vec[2];
  assign frame_out.bitangent_x      = out_vec[3];
  assign frame_out.bitangent_y      = out_vec[4];
  assign frame_out.bitangent_z      = out_vec[5];
  assign frame_out.degenerate       = out_degen;
  assign frame_out.last_of_triangle = out_last;

endmodule

// ===== design/triangle_tangent_frame.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_frame
// Per-triangle unit tangent and bitangent from position and UV deltas.
// ----------------------------------------------------------------------------
// Vertices arrive one transfer each; every third vertex closes a triangle
// and yields three result transfers, one per corner. The first two corners
// of a triangle are accepted without a stall. The back end works one
// triangle at a time: 14 products on one shared multiplier, then for each
// of the two vectors one-bit normalizing shifts, 3 squarings, a bit-serial
// square root and a bit-serial division of each of the three components.
// A triangle with a zero UV determinant skips normalization after the
// products. A two-entry queue lets the front end keep collecting corners
// while the back end is busy.
module triangle_tangent_frame #(
  parameter int INDEX_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  ttf_vertex_if.sink  vertex_in,
  ttf_frame_if.source frame_out
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  ttf_pkg::job_t q_in;
  ttf_pkg::job_t q_out;

  ttf_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .vertex_in (vertex_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  ttf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  ttf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .frame_out (frame_out)
  );

endmodule

// ===== design/ttf_checker.sv =====
// ----------------------------------------------------------------------------
// ttf_checker
// Port-level checks on the tangent frame output channel.
// ----------------------------------------------------------------------------
`include "triangle_tangent_frame_assert.svh"

module ttf_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic        [31:0] target_index,
  input logic signed [15:0] tangent_x,
  input logic signed [15:0] tangent_y,
  input logic signed [15:0] tangent_z,
  input logic signed [15:0] bitangent_x,
  input logic signed [15:0] bitangent_y,
  input logic signed [15:0] bitangent_z,
  input logic               degenerate
);

  logic         stalled;
  logic [128:0] frame_bits;
  logic         vectors_zero;
  logic         no_full_neg;

  assign stalled      = out_valid && !out_ready;
  assign frame_bits   = {target_index, tangent_x, tangent_y, tangent_z,
                         bitangent_x, bitangent_y, bitangent_z, degenerate};
  assign vectors_zero = ({tangent_x, tangent_y, tangent_z,
                          bitangent_x, bitangent_y, bitangent_z} == 96'd0);
  assign no_full_neg  = (tangent_x != -16'sd32768) && (tangent_y != -16'sd32768) &&
                        (tangent_z != -16'sd32768) && (bitangent_x != -16'sd32768) &&
                        (bitangent_y != -16'sd32768) && (bitangent_z != -16'sd32768);

  `TTF_ASSERT_NEXT(a_hold, stalled, out_valid && $stable(frame_bits), "stalled result changed")
  `TTF_ASSERT_NOW(a_degen_zero, out_valid && degenerate, vectors_zero, "degenerate nonzero")
  `TTF_ASSERT_NOW(a_saturate, out_valid, no_full_neg, "component outside saturation range")

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (frame_out.valid),
  .out_ready    (frame_out.ready),
  .target_index (frame_out.target_index),
  .tangent_x    (frame_out.tangent_x),
  .tangent_y    (frame_out.tangent_y),
  .tangent_z    (frame_out.tangent_z),
  .bitangent_x  (frame_out.bitangent_x),
  .bitangent_y  (frame_out.bitangent_y),
  .bitangent_z  (frame_out.bitangent_z),
  .degenerate   (frame_out.degenerate)
);
